// ===== sv/gqg_pkg.sv =====
package gqg_pkg;

    // Glyph table geometry
    localparam int GLYPH_ENTRIES = 224;
    localparam int FIRST_CODE    = 32;
    localparam int GLYPH_IDX_W   = $clog2(GLYPH_ENTRIES);

    // Operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_DRAW  = 2'd2;

    // Vertical alignment codes
    localparam logic [1:0] ALIGN_TOP    = 2'd0;
    localparam logic [1:0] ALIGN_CENTRE = 2'd1;
    localparam logic [1:0] ALIGN_BOTTOM = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_SCALE_X    = 3'd0;
    localparam logic [2:0] REG_SCALE_Y    = 3'd1;
    localparam logic [2:0] REG_INV_TEX_W  = 3'd2;
    localparam logic [2:0] REG_INV_TEX_H  = 3'd3;
    localparam logic [2:0] REG_VALIGN     = 3'd4;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int SUM_W    = 20;
    localparam int FONT_H_W = 9;

    localparam logic signed [39:0] POS_MAX = 40'sd8388607;
    localparam logic signed [39:0] POS_MIN = -40'sd8388608;
    localparam logic [29:0]        TC_MAX  = 30'd65536;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         char_code;
        logic [11:0]        atlas_x;
        logic [11:0]        atlas_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  offset_x;
        logic signed [7:0]  offset_y;
        logic [7:0]         advance;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] x_left;
        logic signed [23:0] y_top;
        logic signed [23:0] x_right;
        logic signed [23:0] y_bottom;
        logic [16:0]        u_left;
        logic [16:0]        v_top;
        logic [16:0]        u_right;
        logic [16:0]        v_bottom;
    } t_out_item;

    typedef struct packed {
        logic [11:0]       atlas_x;
        logic [11:0]       atlas_y;
        logic [7:0]        glyph_width;
        logic [7:0]        glyph_height;
        logic signed [7:0] offset_x;
        logic signed [7:0] offset_y;
        logic [7:0]        advance;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    typedef struct packed {
        logic [11:0] scale_x;
        logic [11:0] scale_y;
        logic [16:0] inv_tex_width;
        logic [16:0] inv_tex_height;
        logic [1:0]  vertical_align;
    } t_cfg;

    // Item after the table lookup
    typedef struct packed {
        logic [1:0]         operation;
        logic               code_ok;
        t_glyph             glyph;
        logic signed [15:0] pen_x;
        logic signed [15:0] pen_y;
    } t_s1;

    // Products handed to the output stage
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic signed [34:0] px_left;
        logic signed [23:0] py_top;
        logic [19:0]        pw;
        logic [19:0]        ph;
        logic [28:0]        u_left;
        logic [29:0]        u_right;
        logic [28:0]        v_top;
        logic [29:0]        v_bottom;
    } t_prod;

    function automatic logic code_in_table(input logic [7:0] code);
        logic [8:0] c;
        c = {1'b0, code};
        return (c >= 9'(FIRST_CODE)) && ((c - 9'(FIRST_CODE)) < 9'(GLYPH_ENTRIES));
    endfunction

    function automatic logic [GLYPH_IDX_W-1:0] code_index(input logic [7:0] code);
        logic [8:0] idx;
        idx = {1'b0, code} - 9'(FIRST_CODE);
        return idx[GLYPH_IDX_W-1:0];
    endfunction

    function automatic logic [23:0] sat_pos(input logic signed [39:0] v);
        logic [23:0] r;
        if (v > POS_MAX) begin
            r = 24'h7FFFFF;
        end else if (v < POS_MIN) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    function automatic logic [16:0] sat_tc(input logic [29:0] v);
        logic [16:0] r;
        if (v > TC_MAX) begin
            r = 17'h10000;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/glyph_quad_generator_top.sv =====
// Bitmap-font glyph quad generator.
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one transaction per
// item: a glyph write loads the table entry for a code and raises the font height,
// a start sets the pen origin and latches the vertical alignment shift, a draw
// of a code in the table produces one quad. Writes, starts, draws of codes
// outside the table and unused operations produce no output transaction.
// Output channel (o_out_valid / i_out_ready / o_out_item) carries screen corners
// in signed Q15.8 and texture coordinates in Q1.16, all saturated.
// A draw passes three registered stages (table read, products, sum and saturate).
// The block takes one item per cycle while the output is not stalled, set by the
// single read port of the glyph RAM and the one-add pen update; the stages are
// elastic, so bubbles from non-drawing items collapse.
// When the receiver stalls, the result holds in the output register and the two
// stages behind it keep filling; input ready drops only once all three are full.
// Reset loads register defaults, clears stage valid flags, pen state, font height
// and the per-entry valid bits of the glyph table, so a never-written entry reads
// as zero; no clearing pass is needed. The APB port (pready tied high) holds the
// scale, reciprocal texture size and alignment registers, one per word address.
module glyph_quad_generator_top import gqg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---- configuration registers ----
    logic [11:0] r_scale_x;
    logic [11:0] r_scale_y;
    logic [16:0] r_inv_tex_w;
    logic [16:0] r_inv_tex_h;
    logic [1:0]  r_valign;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    t_cfg        cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x   <= 12'd256;
            r_scale_y   <= 12'd256;
            r_inv_tex_w <= 17'd256;
            r_inv_tex_h <= 17'd256;
            r_valign    <= ALIGN_TOP;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SCALE_X:   r_scale_x   <= pwdata[11:0];
                REG_SCALE_Y:   r_scale_y   <= pwdata[11:0];
                REG_INV_TEX_W: r_inv_tex_w <= pwdata[16:0];
                REG_INV_TEX_H: r_inv_tex_h <= pwdata[16:0];
                REG_VALIGN:    r_valign    <= pwdata[1:0];
                default:       ;  // addresses past the map are ignored
            endcase
        end
    end

    // Read-back is combinational from the address
    always_comb begin
        unique case (cfg_idx)
            REG_SCALE_X:   prdata = CFG_DATA_W'(r_scale_x);
            REG_SCALE_Y:   prdata = CFG_DATA_W'(r_scale_y);
            REG_INV_TEX_W: prdata = CFG_DATA_W'(r_inv_tex_w);
            REG_INV_TEX_H: prdata = CFG_DATA_W'(r_inv_tex_h);
            REG_VALIGN:    prdata = CFG_DATA_W'(r_valign);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.scale_x        = r_scale_x;
        cfg.scale_y        = r_scale_y;
        cfg.inv_tex_width  = r_inv_tex_w;
        cfg.inv_tex_height = r_inv_tex_h;
        cfg.vertical_align = r_valign;
    end

    // ---- datapath: table lookup -> products -> sum/saturate ----
    logic  s1_valid;
    t_s1   s1;
    logic  s1_take;
    logic  s2_valid;
    t_prod s2;
    logic  out_take;

    gqg_glyph_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_s1_take  (s1_take),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    gqg_quad_calc u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s1_take  (s1_take),
        .i_out_take (out_take),
        .o_s2_valid (s2_valid),
        .o_s2       (s2)
    );

    gqg_quad_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s2_valid  (s2_valid),
        .i_s2        (s2),
        .o_out_take  (out_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // ---- assertions ----
    // Input backpressure only when the lookup stage is occupied
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> s1_valid)
        else $error("input ready dropped with empty lookup stage");

    // A stalled output with a pending product must freeze the product stage
    a_stall_freezes_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && s2_valid) |-> !s1_take)
        else $error("product stage advanced into a stalled output");

    // A new result only ever comes from a valid product stage
    a_out_from_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_take && !s2_valid) |=> !o_out_valid)
        else $error("output valid without a product behind it");

    // Accepting into an occupied lookup stage requires it to drain the same cycle
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && s1_valid) |-> s1_take)
        else $error("lookup stage overwritten");

endmodule

// ===== sv/gqg_ram.sv =====
module gqg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 224
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gqg_glyph_store.sv =====
module gqg_glyph_store import gqg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_ready,
    input  logic     i_s1_take,
    output logic     o_s1_valid,
    output t_s1      o_s1
);

    logic                     r_s1_v;
    t_in_item                 r_item;
    logic                     r_hit;
    logic [GLYPH_ENTRIES-1:0] r_glyph_v;

    logic                   accept;
    logic                   in_code_ok;
    logic [GLYPH_IDX_W-1:0] in_idx;
    logic                   ram_we;
    t_glyph                 wr_glyph;
    t_glyph                 s1_written;
    logic [GLYPH_W-1:0]     ram_rdata;

    assign o_in_ready = !r_s1_v || i_s1_take;
    assign accept     = i_in_valid && o_in_ready;
    assign in_code_ok = code_in_table(i_in_item.char_code);
    assign in_idx     = code_index(i_in_item.char_code);
    assign ram_we     = accept && (i_in_item.operation == OP_WRITE) && in_code_ok;

    always_comb begin
        wr_glyph.atlas_x      = i_in_item.atlas_x;
        wr_glyph.atlas_y      = i_in_item.atlas_y;
        wr_glyph.glyph_width  = i_in_item.glyph_width;
        wr_glyph.glyph_height = i_in_item.glyph_height;
        wr_glyph.offset_x     = i_in_item.offset_x;
        wr_glyph.offset_y     = i_in_item.offset_y;
        wr_glyph.advance      = i_in_item.advance;
    end

    gqg_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_idx),
        .i_wdata (wr_glyph),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    // Per-entry valid: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_v <= '0;
        end else if (ram_we) begin
            r_glyph_v[in_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (i_s1_take) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
            r_hit  <= r_glyph_v[in_idx] && in_code_ok;
        end
    end

    always_comb begin
        s1_written.atlas_x      = r_item.atlas_x;
        s1_written.atlas_y      = r_item.atlas_y;
        s1_written.glyph_width  = r_item.glyph_width;
        s1_written.glyph_height = r_item.glyph_height;
        s1_written.offset_x     = r_item.offset_x;
        s1_written.offset_y     = r_item.offset_y;
        s1_written.advance      = r_item.advance;

        o_s1.operation = r_item.operation;
        o_s1.code_ok   = code_in_table(r_item.char_code);
        o_s1.pen_x     = r_item.pen_x;
        o_s1.pen_y     = r_item.pen_y;
        if (r_item.operation == OP_WRITE) begin
            o_s1.glyph = s1_written;
        end else if (r_hit) begin
            o_s1.glyph = t_glyph'(ram_rdata);
        end else begin
            o_s1.glyph = '0;
        end
    end

    assign o_s1_valid = r_s1_v;

endmodule

// ===== sv/gqg_quad_calc.sv =====
module gqg_quad_calc import gqg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_s1_valid,
    input  t_s1   i_s1,
    output logic  o_s1_take,
    input  logic  i_out_take,
    output logic  o_s2_valid,
    output t_prod o_s2
);

    logic [FONT_H_W-1:0] r_font_h, n_font_h;
    logic signed [15:0]  r_origin_x, n_origin_x;
    logic signed [15:0]  r_origin_y, n_origin_y;
    logic [FONT_H_W-1:0] r_align, n_align;
    logic [SUM_W-1:0]    r_pen_sum, n_pen_sum;
    logic                r_s2_v;
    t_prod               r_s2;

    logic               fire;
    logic               is_write, is_start, is_draw;
    logic signed [9:0]  bottom;
    logic [SUM_W:0]     sum_next;
    logic signed [21:0] pen_off;
    logic signed [10:0] ydiff;
    logic [12:0]        ax_end;
    logic [12:0]        ay_end;
    t_prod              prod;

    assign o_s1_take = !r_s2_v || i_out_take;
    assign fire      = i_s1_valid && o_s1_take;
    assign is_write  = (i_s1.operation == OP_WRITE) && i_s1.code_ok;
    assign is_start  = (i_s1.operation == OP_START);
    assign is_draw   = (i_s1.operation == OP_DRAW) && i_s1.code_ok;

    assign bottom   = $signed({{2{i_s1.glyph.offset_y[7]}}, i_s1.glyph.offset_y})
                    + $signed({2'b00, i_s1.glyph.glyph_height});
    assign sum_next = {1'b0, r_pen_sum} + (SUM_W + 1)'(i_s1.glyph.advance);

    always_comb begin
        n_font_h   = r_font_h;
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_align    = r_align;
        n_pen_sum  = r_pen_sum;
        if (fire && is_write && (bottom > $signed({1'b0, r_font_h}))) begin
            n_font_h = bottom[FONT_H_W-1:0];
        end
        if (fire && is_start) begin
            n_origin_x = i_s1.pen_x;
            n_origin_y = i_s1.pen_y;
            n_pen_sum  = '0;
            unique case (i_cfg.vertical_align)
                ALIGN_TOP:    n_align = '0;
                ALIGN_CENTRE: n_align = {1'b0, r_font_h[FONT_H_W-1:1]};
                ALIGN_BOTTOM: n_align = r_font_h;
                default:      n_align = '0;
            endcase
        end
        if (fire && is_draw) begin
            n_pen_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_h   <= '0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_align    <= '0;
            r_pen_sum  <= '0;
        end else begin
            r_font_h   <= n_font_h;
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_align    <= n_align;
            r_pen_sum  <= n_pen_sum;
        end
    end

    // Products for the quad corners, formed from the state before this draw
    assign pen_off = $signed({2'b00, r_pen_sum})
                   + $signed({{14{i_s1.glyph.offset_x[7]}}, i_s1.glyph.offset_x});
    assign ydiff   = $signed({{3{i_s1.glyph.offset_y[7]}}, i_s1.glyph.offset_y})
                   - $signed({2'b00, r_align});
    assign ax_end  = 13'(i_s1.glyph.atlas_x) + 13'(i_s1.glyph.glyph_width);
    assign ay_end  = 13'(i_s1.glyph.atlas_y) + 13'(i_s1.glyph.glyph_height);

    always_comb begin
        prod.origin_x = r_origin_x;
        prod.origin_y = r_origin_y;
        prod.px_left  = pen_off * $signed({1'b0, i_cfg.scale_x});
        prod.py_top   = ydiff * $signed({1'b0, i_cfg.scale_y});
        prod.pw       = i_s1.glyph.glyph_width * i_cfg.scale_x;
        prod.ph       = i_s1.glyph.glyph_height * i_cfg.scale_y;
        prod.u_left   = i_s1.glyph.atlas_x * i_cfg.inv_tex_width;
        prod.u_right  = ax_end * i_cfg.inv_tex_width;
        prod.v_top    = i_s1.glyph.atlas_y * i_cfg.inv_tex_height;
        prod.v_bottom = ay_end * i_cfg.inv_tex_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (o_s1_take) begin
            r_s2_v <= i_s1_valid && is_draw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && is_draw) begin
            r_s2 <= prod;
        end
    end

    assign o_s2_valid = r_s2_v;
    assign o_s2       = r_s2;

endmodule

// ===== sv/gqg_quad_out.sv =====
module gqg_quad_out import gqg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s2_valid,
    input  t_prod     i_s2,
    output logic      o_out_take,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_out_v;
    t_out_item r_out;

    logic signed [39:0] x1, x2, y1, y2;
    t_out_item          quad;

    assign o_out_take = !r_out_v || i_out_ready;

    assign x1 = $signed({{16{i_s2.origin_x[15]}}, i_s2.origin_x, 8'h00})
              + $signed({{5{i_s2.px_left[34]}}, i_s2.px_left});
    assign x2 = x1 + $signed({20'd0, i_s2.pw});
    assign y1 = $signed({{16{i_s2.origin_y[15]}}, i_s2.origin_y, 8'h00})
              + $signed({{16{i_s2.py_top[23]}}, i_s2.py_top});
    assign y2 = y1 + $signed({20'd0, i_s2.ph});

    always_comb begin
        quad.x_left   = sat_pos(x1);
        quad.y_top    = sat_pos(y1);
        quad.x_right  = sat_pos(x2);
        quad.y_bottom = sat_pos(y2);
        quad.u_left   = sat_tc({1'b0, i_s2.u_left});
        quad.v_top    = sat_tc({1'b0, i_s2.v_top});
        quad.u_right  = sat_tc(i_s2.u_right);
        quad.v_bottom = sat_tc(i_s2.v_bottom);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_out_take) begin
            r_out_v <= i_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_take && i_s2_valid) begin
            r_out <= quad;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

// ===== sim/tb_glyph_quad_generator_top.sv =====
module tb_glyph_quad_generator_top import gqg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation code that the block leaves alone
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Unused alignment setting, behaves as top
    localparam logic [1:0] ALIGN_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PEN_RUN_DRAWS = 20;      // short line of the widest advance

    // ------------------------------------------------------------------
    // Quad predictor and scoreboard: tracks glyph table, pen and alignment
    // state, computes the quad each accepted in-table draw must produce, and checks
    // output transactions against the oldest pending quad.
    // ------------------------------------------------------------------
    class glyph_quad_model;
        t_glyph             glyphs [GLYPH_ENTRIES];
        int                 font_height;
        int                 align_shift;
        int                 pen_sum;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        t_cfg               regs;
        t_out_item          quads [$];
        int                 errors;
        int                 quads_checked;
        int                 reg_writes;
        int                 n_write, n_start, n_draw, n_other;

        function new();
            foreach (glyphs[i]) glyphs[i] = '0;
            font_height = 0;
            align_shift = 0;
            pen_sum     = 0;
            origin_x    = '0;
            origin_y    = '0;
            regs.scale_x        = 12'd256;
            regs.scale_y        = 12'd256;
            regs.inv_tex_width  = 17'd256;
            regs.inv_tex_height = 17'd256;
            regs.vertical_align = ALIGN_TOP;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            reg_writes++;
            case (idx)
                REG_SCALE_X:   regs.scale_x        = data[11:0];
                REG_SCALE_Y:   regs.scale_y        = data[11:0];
                REG_INV_TEX_W: regs.inv_tex_width  = data[16:0];
                REG_INV_TEX_H: regs.inv_tex_height = data[16:0];
                REG_VALIGN:    regs.vertical_align = data[1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [2:0] idx);
            case (idx)
                REG_SCALE_X:   return 32'(regs.scale_x);
                REG_SCALE_Y:   return 32'(regs.scale_y);
                REG_INV_TEX_W: return 32'(regs.inv_tex_width);
                REG_INV_TEX_H: return 32'(regs.inv_tex_height);
                REG_VALIGN:    return 32'(regs.vertical_align);
                default:       return '0;
            endcase
        endfunction

        function void check_reg(logic [2:0] idx, logic [31:0] got);
            logic [31:0] want;
            want = reg_value(idx);
            if (got !== want) begin
                errors++;
                $error("register %0d readback: expected 0x%08h, got 0x%08h", idx, want, got);
            end
        endfunction

        function logic [23:0] clip_pos(longint v);
            longint c;
            c = v;
            if (c > 64'sd8388607) c = 64'sd8388607;
            if (c < -64'sd8388608) c = -64'sd8388608;
            return c[23:0];
        endfunction

        function logic [16:0] clip_tc(longint v);
            return (v > 64'sd65536) ? 17'h10000 : v[16:0];
        endfunction

        function void take_item(t_in_item it);
            bit        in_range;
            int        slot;
            int        bottom;
            t_glyph    g;
            t_out_item q;
            longint    x1, y1, x2, y2;

            in_range = (int'(it.char_code) >= FIRST_CODE) &&
                       (int'(it.char_code) < FIRST_CODE + GLYPH_ENTRIES);
            slot = int'(it.char_code) - FIRST_CODE;
            case (it.operation)
                OP_WRITE: begin
                    n_write++;
                    if (in_range) begin
                        g.atlas_x      = it.atlas_x;
                        g.atlas_y      = it.atlas_y;
                        g.glyph_width  = it.glyph_width;
                        g.glyph_height = it.glyph_height;
                        g.offset_x     = it.offset_x;
                        g.offset_y     = it.offset_y;
                        g.advance      = it.advance;
                        glyphs[slot]   = g;
                        bottom = int'($signed(g.offset_y)) + int'(g.glyph_height);
                        if (bottom > font_height) font_height = bottom;
                    end
                end
                OP_START: begin
                    n_start++;
                    origin_x = it.pen_x;
                    origin_y = it.pen_y;
                    pen_sum  = 0;
                    case (regs.vertical_align)
                        ALIGN_CENTRE: align_shift = font_height >> 1;
                        ALIGN_BOTTOM: align_shift = font_height;
                        default:      align_shift = 0;
                    endcase
                end
                OP_DRAW: begin
                    n_draw++;
                    if (in_range) begin
                        g  = glyphs[slot];
                        x1 = longint'(origin_x) * 256 +
                             (longint'(pen_sum) + longint'($signed(g.offset_x))) *
                             longint'(regs.scale_x);
                        y1 = longint'(origin_y) * 256 +
                             (longint'($signed(g.offset_y)) - longint'(align_shift)) *
                             longint'(regs.scale_y);
                        x2 = x1 + longint'(g.glyph_width) * longint'(regs.scale_x);
                        y2 = y1 + longint'(g.glyph_height) * longint'(regs.scale_y);
                        q.x_left   = clip_pos(x1);
                        q.y_top    = clip_pos(y1);
                        q.x_right  = clip_pos(x2);
                        q.y_bottom = clip_pos(y2);
                        q.u_left   = clip_tc(longint'(g.atlas_x) * longint'(regs.inv_tex_width));
                        q.v_top    = clip_tc(longint'(g.atlas_y) * longint'(regs.inv_tex_height));
                        q.u_right  = clip_tc((longint'(g.atlas_x) + longint'(g.glyph_width)) *
                                             longint'(regs.inv_tex_width));
                        q.v_bottom = clip_tc((longint'(g.atlas_y) + longint'(g.glyph_height)) *
                                             longint'(regs.inv_tex_height));
                        quads.insert(quads.size(), q);
                        pen_sum += int'(g.advance);
                        if (pen_sum > 20'hFFFFF) pen_sum = 20'hFFFFF;
                    end
                end
                default: n_other++;
            endcase
        endfunction

        function void compare_field(string name, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                errors++;
                $error("%s: expected 0x%06h, got 0x%06h", name, want, got);
            end
        endfunction

        function void check_quad(t_out_item got);
            t_out_item want;
            if (quads.size() == 0) begin
                errors++;
                $error("quad transaction with nothing pending");
                return;
            end
            want = quads.pop_front();
            quads_checked++;
            compare_field("x_left",   want.x_left,   got.x_left);
            compare_field("y_top",    want.y_top,    got.y_top);
            compare_field("x_right",  want.x_right,  got.x_right);
            compare_field("y_bottom", want.y_bottom, got.y_bottom);
            compare_field("u_left",   24'(want.u_left),   24'(got.u_left));
            compare_field("v_top",    24'(want.v_top),    24'(got.v_top));
            compare_field("u_right",  24'(want.u_right),  24'(got.u_right));
            compare_field("v_bottom", 24'(want.v_bottom), 24'(got.v_bottom));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [CFG_DATA_W-1:0] pwdata      = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    glyph_quad_model model = new();

    t_in_item item_fifo [$];    // stimulus waiting to be offered
    logic [7:0] known_codes [$]; // codes that got a glyph written
    bit       in_sent;           // input transaction taken at the last rising edge
    bit       gaps_on      = 1'b1;
    bit       hold_request = 1'b0;
    int       cycle_count;
    int       hold_count;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    glyph_quad_generator_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Monitor: both channels are sampled at the rising edge, before the
    // DUT's registers update. An accepted input feeds the predictor; an
    // accepted output is checked against the oldest pending quad.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            model.take_item(i_in_item);
            in_sent = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            model.check_quad(o_out_item);
        end
    end

    // Input driver: at the falling edge, once the current transaction is gone
    // (or nothing was offered), either offer the next queued item or idle.
    // A held valid is never dropped and reasserted within one step.
    always @(negedge i_clk) begin
        if (!i_in_valid || in_sent) begin
            in_sent = 1'b0;
            if (item_fifo.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 8)) begin
                i_in_item  <= item_fifo.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output ready: random stalls, plus one long hold-off on request. The
    // hold is counted here so the sender keeps pushing and the pipe backs up.
    initial begin : out_ready_drv
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold_count++;
                end
            end
            i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 8);
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d quads still pending",
                 cycle_count, model.quads.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Item builders. Fields an operation ignores carry random bits.
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(logic [1:0] op, logic [7:0] code);
        logic [127:0] raw;
        t_in_item     it;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        it  = raw[$bits(t_in_item)-1:0];
        it.operation = op;
        it.char_code = code;
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        if (it.operation == OP_WRITE && int'(it.char_code) >= FIRST_CODE)
            known_codes.insert(known_codes.size(), it.char_code);
        item_fifo.insert(item_fifo.size(), it);
    endtask

    task automatic push_write(input logic [7:0] code, input logic [11:0] ax,
                              input logic [11:0] ay, input logic [7:0] w,
                              input logic [7:0] h, input logic signed [7:0] ox,
                              input logic signed [7:0] oy, input logic [7:0] adv);
        t_in_item it;
        it = make_item(OP_WRITE, code);
        it.atlas_x      = ax;
        it.atlas_y      = ay;
        it.glyph_width  = w;
        it.glyph_height = h;
        it.offset_x     = ox;
        it.offset_y     = oy;
        it.advance      = adv;
        push_item(it);
    endtask

    task automatic push_start(input logic signed [15:0] px, input logic signed [15:0] py);
        t_in_item it;
        it = make_item(OP_START, 8'($urandom()));
        it.pen_x = px;
        it.pen_y = py;
        push_item(it);
    endtask

    task automatic push_draw(input logic [7:0] code);
        push_item(make_item(OP_DRAW, code));
    endtask

    // ------------------------------------------------------------------
    // Register access over APB. Each transfer starts and ends at a falling
    // edge; psel stays up between back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready) model.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        model.check_reg(idx, prdata);
        @(negedge i_clk);
    endtask

    task automatic read_back_regs();
        for (int r = REG_SCALE_X; r <= REG_VALIGN; r++) apb_read(3'(r));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Quiet point: all stimulus taken, no quad pending, and a further wait
    // so that writes and starts still in the pipe have landed.
    task automatic wait_idle();
        while (item_fifo.size() != 0 || i_in_valid || model.quads.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all registers with junk above each width, poke an address past
    // the register list, then read everything back.
    task automatic configure(input logic [11:0] sx, input logic [11:0] sy,
                             input logic [16:0] iw, input logic [16:0] ih,
                             input logic [1:0] va);
        wait_idle();
        @(negedge i_clk);
        apb_write(REG_SCALE_X,   {20'($urandom()), sx});
        apb_write(REG_SCALE_Y,   {20'($urandom()), sy});
        apb_write(REG_INV_TEX_W, {15'($urandom()), iw});
        apb_write(REG_INV_TEX_H, {15'($urandom()), ih});
        apb_write(REG_VALIGN,    {30'($urandom()), va});
        apb_write(3'($urandom_range(int'(REG_VALIGN) + 1, 7)), $urandom());
        read_back_regs();
        @(posedge i_clk);
    endtask

    task automatic configure_typical();
        configure(12'($urandom_range(64, 768)), 12'($urandom_range(64, 768)),
                  17'($urandom_range(1, 512)), 17'($urandom_range(1, 512)),
                  2'($urandom_range(0, 3)));
    endtask

    // Mostly well-formed text: a few glyph loads, a start, then draws of
    // loaded codes mixed with more loads, restarts and some junk.
    task automatic run_traffic(input int n);
        t_in_item   it;
        int         pick;
        logic [7:0] code;
        for (int k = 0; k < n; k++) begin
            pick = (k < 4) ? 0 : (k == 4) ? 15 : $urandom_range(0, 99);
            if (pick < 12) begin
                code = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(FIRST_CODE, 255))
                                                    : 8'($urandom());
                push_item(make_item(OP_WRITE, code));
            end else if (pick < 20) begin
                it = make_item(OP_START, 8'($urandom()));
                if ($urandom_range(0, 1)) begin
                    it.pen_x = it.pen_x >>> 4;
                    it.pen_y = it.pen_y >>> 4;
                end
                push_item(it);
            end else if (pick < 93) begin
                if (known_codes.size() != 0 && $urandom_range(0, 99) < 85)
                    code = known_codes[$urandom_range(0, known_codes.size() - 1)];
                else
                    code = 8'($urandom());
                push_draw(code);
            end else if (pick < 97) begin
                push_item(make_item(OP_UNUSED, 8'($urandom())));
            end else begin
                push_item(make_item($urandom_range(0, 1) ? OP_WRITE : OP_DRAW,
                                    8'($urandom_range(0, FIRST_CODE - 1))));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        read_back_regs();   // reset values
        @(posedge i_clk);

        // Reset settings. Draw before any start or load: zero glyph at the
        // reset origin. Then loads at the low end of the table, codes below the
        // table, an unused operation and a few draws.
        push_draw(8'd65);
        push_write(8'd32, 12'd0, 12'd0, 8'd0, 8'd0, 8'sd0, 8'sd0, 8'd0);
        push_write(8'd65, 12'd100, 12'd200, 8'd10, 8'd12, -8'sd128, -8'sd128, 8'd9);
        push_write(8'd40, 12'd7, 12'd9, 8'd5, 8'd25, 8'sd3, 8'sd0, 8'd6);  // height 25
        push_write(8'd31, 12'd1, 12'd2, 8'd3, 8'd200, 8'sd4, 8'sd100, 8'd5);
        push_write(8'd0, 12'd1, 12'd2, 8'd3, 8'd200, 8'sd4, 8'sd100, 8'd5);
        push_start(-16'sd32768, 16'sd32767);
        push_draw(8'd65);
        push_draw(8'd32);
        push_draw(8'd31);
        push_draw(8'd0);
        push_item(make_item(OP_UNUSED, 8'd65));
        push_draw(8'd40);
        push_draw(8'd65);

        // Centre alignment on an odd font height; a later taller glyph must
        // not move the shift until the next start.
        configure(12'd128, 12'd384, 17'd4096, 17'd2048, ALIGN_CENTRE);
        push_start(16'sd100, 16'sd200);
        push_write(8'd255, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'sd127, 8'sd127, 8'd255);
        push_draw(8'd40);
        push_draw(8'd255);
        push_start(16'sd0, 16'sd0);
        push_draw(8'd255);

        // Largest scales and reciprocals, bottom alignment: saturation.
        configure(12'd4095, 12'd4095, 17'd65536, 17'd65536, ALIGN_BOTTOM);
        push_start(16'sd32767, -16'sd32768);
        push_draw(8'd255);
        push_draw(8'd32);
        push_draw(8'd65);

        // Zero scales and reciprocals; unused alignment acts as top.
        configure(12'd0, 12'd0, 17'd0, 17'd0, ALIGN_UNUSED);
        push_start(-16'sd1, -16'sd1);
        push_draw(8'd255);
        push_draw(8'd40);

        // Random text runs over several settings
        configure_typical();
        run_traffic(110);

        configure_typical();
        gaps_on = 1'b0;     // long stretch with no idling on either side
        run_traffic(110);
        wait_idle();
        gaps_on = 1'b1;

        configure_typical();
        hold_request = 1'b1; // receiver holds off while input keeps coming
        run_traffic(110);

        configure(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
                  2'($urandom_range(0, 3)));
        run_traffic(110);

        configure_typical();
        run_traffic(110);

        // Line of one glyph with the widest advance, pen sum keeps growing
        configure(12'd1, 12'd256, 17'd16, 17'd16, ALIGN_TOP);
        push_write(8'd127, 12'($urandom()), 12'($urandom()), 8'($urandom()),
                   8'($urandom()), 8'($urandom()), 8'($urandom()), 8'd255);
        push_start(16'sd0, 16'sd0);
        repeat (PEN_RUN_DRAWS) push_draw(8'd127);

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d input transactions: %0d glyph loads, %0d starts, %0d draws,",
                 model.n_write + model.n_start + model.n_draw + model.n_other,
                 model.n_write, model.n_start, model.n_draw);
        $display("%0d unused operations; %0d quads checked over %0d register writes.",
                 model.n_other, model.quads_checked, model.reg_writes);
        if (model.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
